### rtl/sdlm_pkg.sv
package sdlm_pkg;

    localparam int SMP_W      = 16;
    localparam int CFG_W      = 9;
    localparam int LVL_W      = 7;
    localparam int THR_W      = 32;
    localparam int LVL_STEPS  = 99;
    localparam int TAB_DEPTH  = 128;
    localparam int NOISE_FLOOR = 120;
    localparam int LEVEL_STEP  = 60;
    localparam int SERIES_TERMS = 24;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_END,
        ST_DIV,
        ST_MAP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic frame;
        logic forget;
        logic blk_end;
        logic div_step;
        logic map_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last_frame;
        logic div_last;
        logic map_last;
    } t_sts;

    typedef logic [TAB_DEPTH-1:0][THR_W-1:0] t_thr_tab;

    // Shift-and-subtract quotient, used only while building the constant table.
    function automatic logic [63:0] shift_sub_quo(input logic [63:0] num,
                                                  input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Twice the inverse hyperbolic tangent of num/den in Q28.
    function automatic logic [63:0] log_ratio_q28(input logic [63:0] num,
                                                  input logic [63:0] den);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] s;
        z = shift_sub_quo(num << 28, den);
        z2 = (z * z) >> 28;
        p = z;
        s = '0;
        for (int i = 0; i < SERIES_TERMS; i++) begin
            s = s + shift_sub_quo(p, 64'(2 * i + 1));
            p = (p * z2) >> 28;
        end
        return s << 1;
    endfunction

    // Squared-level thresholds per step; unused entries can never be met.
    function automatic t_thr_tab build_thresholds();
        t_thr_tab    tab;
        logic [63:0] ln2;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] ln;
        logic [63:0] curve;
        logic [63:0] v;
        ln2 = log_ratio_q28(64'd1, 64'd3);
        for (int k = 0; k < TAB_DEPTH; k++) begin
            tab[k] = '1;
            if (k >= 1 && k <= LVL_STEPS) begin
                b = 64'(100 - k);
                e = '0;
                for (int j = 0; j < 7; j++) begin
                    if (b * 2 <= 64'd100) begin
                        b = b * 2;
                        e = e + 1;
                    end
                end
                ln = e * ln2 + log_ratio_q28(64'd100 - b, 64'd100 + b);
                curve = (64'd10 * ln + 64'd2048) >> 12;
                v = 64'(NOISE_FLOOR) * 64'd65536 + 64'(LEVEL_STEP) * curve;
                if (v <= 64'h8000_0000) begin
                    tab[k] = THR_W'((v * v + 64'hFFFF_FFFF) >> 32);
                end
            end
        end
        return tab;
    endfunction

    localparam t_thr_tab THRESH = build_thresholds();

endpackage

### rtl/sdlm_ctrl.sv
module sdlm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tuser,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  sdlm_pkg::t_sts i_sts,
    output sdlm_pkg::t_cmd o_cmd
);
    import sdlm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && !s_axis_tuser && i_sts.last_frame) begin
                    n_state = ST_END;
                end
            end
            ST_END: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                if (i_sts.map_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.frame  = w_accept && !s_axis_tuser;
                o_cmd.forget = w_accept && s_axis_tuser;
            end
            ST_END: begin
                o_cmd.blk_end = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_MAP: begin
                o_cmd.map_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;

endmodule

### rtl/sdlm_dp.sv
module sdlm_dp #(
    parameter int MAX_BLOCK_FRAMES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [31:0]                  s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         i_cfg_we,
    input  logic [sdlm_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic [7:0]                   m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,
    input  sdlm_pkg::t_cmd               i_cmd,
    output sdlm_pkg::t_sts               o_sts
);
    import sdlm_pkg::*;

    localparam int FR_W  = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int ABS_W = SMP_W + $clog2(MAX_BLOCK_FRAMES);
    localparam int SQ_W  = 2 * SMP_W - 1 + $clog2(MAX_BLOCK_FRAMES);
    localparam int CMP_W = (FR_W > CFG_W) ? FR_W : CFG_W;
    localparam int DC_W  = $clog2(SQ_W);
    localparam int BIT_W = $clog2(LVL_W);

    logic [CFG_W-1:0] r_min_det;
    logic             r_chosen;
    logic             r_slot;
    logic [ABS_W-1:0] r_abs0;
    logic [ABS_W-1:0] r_abs1;
    logic [SQ_W-1:0]  r_sq0;
    logic [SQ_W-1:0]  r_sq1;
    logic [FR_W-1:0]  r_frames;

    logic [FR_W-1:0]  r_divisor;
    logic [FR_W-1:0]  r_rem;
    logic [SQ_W-1:0]  r_quo;
    logic [DC_W-1:0]  r_div_cnt;
    logic [LVL_W-1:0] r_lvl;
    logic [BIT_W-1:0] r_bit;

    logic [LVL_W-1:0] r_out_level;
    logic             r_out_live;
    logic             r_out_known;

    logic [SMP_W-1:0]   w_smp0;
    logic [SMP_W-1:0]   w_smp1;
    logic [SMP_W-1:0]   w_abs0;
    logic [SMP_W-1:0]   w_abs1;
    logic [2*SMP_W-1:0] w_sqr0;
    logic [2*SMP_W-1:0] w_sqr1;
    logic               n_chosen;
    logic               n_slot;
    logic               w_live;
    logic [FR_W:0]      w_shift;
    logic               w_ge;
    logic [FR_W:0]      w_diff;
    logic [LVL_W-1:0]   w_cand;
    logic [THR_W-1:0]   w_thr;

    assign w_smp0 = s_axis_tdata[SMP_W-1:0];
    assign w_smp1 = s_axis_tdata[2*SMP_W-1:SMP_W];
    assign w_abs0 = w_smp0[SMP_W-1] ? (~w_smp0 + 1'b1) : w_smp0;
    assign w_abs1 = w_smp1[SMP_W-1] ? (~w_smp1 + 1'b1) : w_smp1;
    assign w_sqr0 = w_abs0 * w_abs0;
    assign w_sqr1 = w_abs1 * w_abs1;

    assign o_sts.last_frame = s_axis_tlast || (r_frames == FR_W'(MAX_BLOCK_FRAMES - 1));
    assign o_sts.div_last   = (r_div_cnt == DC_W'(SQ_W - 1));
    assign o_sts.map_last   = (r_bit == '0);

    always_comb begin
        n_chosen = r_chosen;
        n_slot   = r_slot;
        if (!r_chosen && (CMP_W'(r_frames) > CMP_W'(r_min_det))) begin
            n_chosen = 1'b1;
            n_slot   = (r_abs1 > r_abs0);
        end
        w_live = n_chosen ? n_slot : 1'b0;
    end

    assign w_shift = {r_rem, r_quo[SQ_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_divisor});
    assign w_diff  = w_shift - {1'b0, r_divisor};

    assign w_cand = r_lvl | (LVL_W'(1) << r_bit);
    assign w_thr  = THRESH[w_cand];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_det <= CFG_RESET;
            r_chosen  <= 1'b0;
            r_slot    <= 1'b0;
            r_abs0    <= '0;
            r_abs1    <= '0;
            r_sq0     <= '0;
            r_sq1     <= '0;
            r_frames  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_det <= i_cfg_wdata;
            end
            if (i_cmd.forget) begin
                r_chosen <= 1'b0;
                r_slot   <= 1'b0;
            end
            if (i_cmd.frame) begin
                r_abs0   <= r_abs0 + ABS_W'(w_abs0);
                r_abs1   <= r_abs1 + ABS_W'(w_abs1);
                r_sq0    <= r_sq0 + SQ_W'(w_sqr0);
                r_sq1    <= r_sq1 + SQ_W'(w_sqr1);
                r_frames <= r_frames + 1'b1;
            end
            if (i_cmd.blk_end) begin
                r_chosen <= n_chosen;
                r_slot   <= n_slot;
                r_abs0   <= '0;
                r_abs1   <= '0;
                r_sq0    <= '0;
                r_sq1    <= '0;
                r_frames <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_bit     <= '0;
        end else begin
            if (i_cmd.blk_end) begin
                r_div_cnt <= '0;
                r_bit     <= BIT_W'(LVL_W - 1);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end else if (i_cmd.map_step && r_bit != '0) begin
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_end) begin
            r_divisor <= r_frames;
            r_rem     <= '0;
            r_quo     <= w_live ? r_sq1 : r_sq0;
            r_lvl     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[FR_W-1:0] : w_shift[FR_W-1:0];
            r_quo <= {r_quo[SQ_W-2:0], w_ge};
        end else if (i_cmd.map_step) begin
            if (SQ_W'(w_thr) <= r_quo) begin
                r_lvl <= w_cand;
            end
        end
        if (i_cmd.load_out) begin
            r_out_level <= r_lvl;
            r_out_live  <= r_chosen ? r_slot : 1'b0;
            r_out_known <= r_chosen;
        end
    end

    assign m_axis_tdata = {1'b0, r_out_level};
    assign m_axis_tuser = {r_out_known, r_out_live};

endmodule

### rtl/stereo_slot_detect_level_meter.sv
// Channel        Direction  Transaction contents
// s_axis         in         one stereo frame, or a request to forget the chosen slot
// m_axis         out        level of the live slot for one finished block
// i_cfg          in         frame count a block must exceed for slot detection
//
// A frame that does not end a block is taken while idle, and the next one can follow
// directly. A frame that ends a block occupies the block while the one-bit-per-cycle
// divider forms the mean square, followed by a seven-step search of the level table.
// Reset is synchronous and active low; it clears the block sums and the slot choice.
// A stalled result waits in the output register; the next block end waits behind it.
module stereo_slot_detect_level_meter #(
    parameter int MAX_BLOCK_FRAMES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // slot0_sample, slot1_sample
    input  logic                       s_axis_tuser,  // op
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // level, zero pad
    output logic [1:0]                 m_axis_tuser,  // live_slot, slot_known
    input  logic                       i_cfg_we,
    input  logic [sdlm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import sdlm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sdlm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    sdlm_dp #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

endmodule

### sim/tb_stereo_slot_detect_level_meter.sv
`timescale 1ns / 100ps

module tb_stereo_slot_detect_level_meter;

    localparam int BLOCK_MAX    = 256;
    localparam int FLOOR_LEVEL  = 120;
    localparam int STEP_SIZE    = 60;
    localparam int SETTLE       = 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1632;
    localparam int N_PHASES     = 8;
    localparam int N_DIRECTED   = 18;
    localparam int CW           = sdlm_pkg::CFG_W;

    typedef enum logic {
        OP_FRAME,
        OP_FORGET
    } t_meter_op;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_RUN,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [6:0] level;
        logic       live;
        logic       known;
    } t_meter_result;

    typedef struct packed {
        t_row_kind     kind;
        t_meter_op     op;
        logic [15:0]   s0;
        logic [15:0]   s1;
        logic          last;
        logic [8:0]    arg;
        logic          typed;
        logic          has_res;
        t_meter_result res;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              i_cfg_we = 1'b0;
    logic [CW-1:0]     i_cfg_wdata = '0;

    // Shadow of the meter: detection threshold, slot choice and block sums.
    logic [CW-1:0]     min_frames_cfg = sdlm_pkg::CFG_RESET;
    logic              picked_valid = 1'b0;
    logic              picked_slot = 1'b0;
    logic [63:0]       abs_acc [2];
    logic [63:0]       sq_acc [2];
    int unsigned       frames_acc = 0;
    logic [63:0]       step_sq [1:99];

    t_meter_result     expected_levels [$];
    int                fail_count = 0;
    int                items_sent = 0;
    int                blocks_checked = 0;
    int                full_blocks = 0;
    int                latches = 0;
    int                cfg_writes = 0;
    int                send_calm = 0;
    int                recv_calm = 0;
    int                cycle_count = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, OP_FRAME,  16'h0000, 16'h0000, 1'b1, 9'd0,   1'b1, 1'b1, '{7'd0,  1'b0, 1'b0}},
        '{ROW_ITEM, OP_FRAME,  16'h8000, 16'h0000, 1'b1, 9'd0,   1'b1, 1'b1, '{7'd99, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_FRAME,  16'h7FFF, 16'h8000, 1'b1, 9'd0,   1'b1, 1'b1, '{7'd99, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_FRAME,  16'hFFFF, 16'h0001, 1'b1, 9'd0,   1'b1, 1'b1, '{7'd0,  1'b0, 1'b0}},
        '{ROW_ITEM, OP_FORGET, 16'h7FFF, 16'h8000, 1'b1, 9'd0,   1'b1, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FRAME,  16'h00C8, 16'hFED4, 1'b0, 9'd0,   1'b1, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FORGET, 16'hFFFF, 16'hFFFF, 1'b0, 9'd0,   1'b1, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FRAME,  16'hFF38, 16'h012C, 1'b1, 9'd0,   1'b0, 1'b0, 9'd0},
        '{ROW_CFG,  OP_FRAME,  16'h0000, 16'h0000, 1'b0, 9'd0,   1'b0, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FRAME,  16'h0064, 16'hEC78, 1'b1, 9'd0,   1'b0, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FRAME,  16'h1388, 16'h1388, 1'b1, 9'd0,   1'b0, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FORGET, 16'h0000, 16'h0000, 1'b0, 9'd0,   1'b1, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FRAME,  16'h0007, 16'hFFF9, 1'b1, 9'd0,   1'b1, 1'b1, '{7'd0,  1'b0, 1'b1}},
        '{ROW_CFG,  OP_FRAME,  16'h0000, 16'h0000, 1'b0, 9'd256, 1'b0, 1'b0, 9'd0},
        '{ROW_ITEM, OP_FORGET, 16'h0000, 16'h0000, 1'b0, 9'd0,   1'b1, 1'b0, 9'd0},
        '{ROW_RUN,  OP_FRAME,  16'h8000, 16'h0100, 1'b0, 9'd256, 1'b1, 1'b1, '{7'd99, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_FRAME,  16'h03E8, 16'h07D0, 1'b1, 9'd0,   1'b0, 1'b0, 9'd0},
        '{ROW_CFG,  OP_FRAME,  16'h0000, 16'h0000, 1'b0, 9'd32,  1'b0, 1'b0, 9'd0}
    };

    stereo_slot_detect_level_meter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Twice the inverse hyperbolic tangent of num/den, Q28.
    function automatic logic [63:0] atanh2_q28(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] s;
        z = (num << 28) / den;
        z2 = (z * z) >> 28;
        p = z;
        s = '0;
        for (int i = 0; i < 24; i++) begin
            s = s + p / 64'(2 * i + 1);
            p = (p * z2) >> 28;
        end
        return s << 1;
    endfunction

    function automatic void build_step_table();
        logic [63:0] ln2;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] ln;
        logic [63:0] curve;
        logic [63:0] v;
        ln2 = atanh2_q28(64'd1, 64'd3);
        for (int k = 1; k <= 99; k++) begin
            b = 64'(100 - k);
            e = '0;
            while (b * 2 <= 64'd100) begin
                b = b * 2;
                e = e + 1;
            end
            ln = e * ln2 + atanh2_q28(64'd100 - b, 64'd100 + b);
            curve = (64'd10 * ln + 64'd2048) >> 12;
            v = 64'(FLOOR_LEVEL) * 64'd65536 + 64'(STEP_SIZE) * curve;
            step_sq[k] = (v > 64'h8000_0000) ? '1 : v * v;
        end
    endfunction

    function automatic void step_meter(input t_meter_op op, input logic [15:0] s0,
                                       input logic [15:0] s1, input logic last,
                                       output logic got, output t_meter_result res);
        logic [16:0] mag [2];
        logic [63:0] mean;
        logic        slot;
        int          count;
        got = 1'b0;
        res = '0;
        if (op == OP_FORGET) begin
            picked_valid = 1'b0;
            picked_slot = 1'b0;
            return;
        end
        mag[0] = s0[15] ? 17'h10000 - {1'b0, s0} : {1'b0, s0};
        mag[1] = s1[15] ? 17'h10000 - {1'b0, s1} : {1'b0, s1};
        for (int i = 0; i < 2; i++) begin
            abs_acc[i] = abs_acc[i] + 64'(mag[i]);
            sq_acc[i] = sq_acc[i] + 64'(mag[i]) * 64'(mag[i]);
        end
        frames_acc++;
        if (!last && frames_acc < BLOCK_MAX) begin
            return;
        end
        if (frames_acc == BLOCK_MAX) begin
            full_blocks++;
        end
        if (!picked_valid && frames_acc > min_frames_cfg) begin
            picked_slot = abs_acc[1] > abs_acc[0];
            picked_valid = 1'b1;
            latches++;
        end
        slot = picked_valid ? picked_slot : 1'b0;
        mean = sq_acc[slot] / 64'(frames_acc);
        count = 0;
        for (int k = 1; k <= 99; k++) begin
            if ((mean << 32) >= step_sq[k]) begin
                count++;
            end
        end
        res.level = 7'(count);
        res.live = slot;
        res.known = picked_valid;
        got = 1'b1;
        for (int i = 0; i < 2; i++) begin
            abs_acc[i] = '0;
            sq_acc[i] = '0;
        end
        frames_acc = 0;
    endfunction

    function automatic int draw_gap(inout int calm);
        int g;
        g = $urandom_range(0, 6);
        if (calm > 0) begin
            calm--;
            g = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return g;
    endfunction

    task automatic send_item(input t_meter_op op, input logic [15:0] s0, input logic [15:0] s1,
                             input logic last, input logic typed, input logic typed_has,
                             input t_meter_result typed_res);
        int            gap;
        logic          got;
        t_meter_result res;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s1, s0};
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        step_meter(op, s0, s1, last, got, res);
        if (typed) begin
            got = typed_has;
            res = typed_res;
        end
        if (got) begin
            expected_levels.push_back(res);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CW-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        min_frames_cfg = value;
        cfg_writes++;
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped by the cycle limit after %0d cycles.", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int            gap;
        t_meter_result want;
        wait (i_rst_n);
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            blocks_checked++;
            if (expected_levels.size() == 0) begin
                fail_count++;
                $display("%0t: level transaction with no block pending, tdata %0d tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_levels.pop_front();
                if (m_axis_tdata !== {1'b0, want.level}) begin
                    fail_count++;
                    $display("%0t: level expected %0d, actual %0d",
                             $time, want.level, m_axis_tdata);
                end
                if (m_axis_tuser[0] !== want.live) begin
                    fail_count++;
                    $display("%0t: live_slot expected %0d, actual %0d",
                             $time, want.live, m_axis_tuser[0]);
                end
                if (m_axis_tuser[1] !== want.known) begin
                    fail_count++;
                    $display("%0t: slot_known expected %0d, actual %0d",
                             $time, want.known, m_axis_tuser[1]);
                end
            end
        end
    end

    initial begin
        t_stim_row     row;
        int            phase_items;
        int            len;
        int            pick;
        int            mag;
        int            amp [2];
        logic [15:0]   smp [2];
        logic          last;
        logic [CW-1:0] cfg_plan [N_PHASES];

        for (int i = 0; i < 2; i++) begin
            abs_acc[i] = '0;
            sq_acc[i] = '0;
        end
        build_step_table();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_CFG: begin
                    wait_drained();
                    write_cfg(row.arg);
                end
                ROW_RUN: begin
                    for (int f = 0; f < int'(row.arg); f++) begin
                        send_item(row.op, row.s0, row.s1, row.last,
                                  row.typed && (f == int'(row.arg) - 1), row.has_res, row.res);
                    end
                end
                default: begin
                    send_item(row.op, row.s0, row.s1, row.last, row.typed, row.has_res, row.res);
                end
            endcase
        end

        cfg_plan = '{9'd0, 9'd256, 9'd1, 9'd255, 9'd0, 9'd32, 9'd0, 9'd0};
        cfg_plan[4] = CW'($urandom_range(0, 256));
        cfg_plan[6] = CW'($urandom_range(0, 64));

        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            write_cfg(cfg_plan[phase]);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / N_PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    len = $urandom_range(1, 12);
                end else if (pick < 88) begin
                    len = $urandom_range(13, 64);
                end else if (pick < 96) begin
                    len = $urandom_range(65, 255);
                end else begin
                    len = $urandom_range(256, 300);
                end
                if (len > RANDOM_ITEMS / N_PHASES - phase_items) begin
                    len = RANDOM_ITEMS / N_PHASES - phase_items;
                end
                for (int s = 0; s < 2; s++) begin
                    case ($urandom_range(0, 4))
                        0: amp[s] = 0;
                        1: amp[s] = 40;
                        2: amp[s] = 400;
                        3: amp[s] = 4000;
                        default: amp[s] = 65536;
                    endcase
                end
                for (int f = 0; f < len; f++) begin
                    if ($urandom_range(0, 32) == 0) begin
                        send_item(OP_FORGET, 16'($urandom), 16'($urandom),
                                  1'($urandom), 1'b0, 1'b0, '0);
                        phase_items++;
                    end
                    for (int s = 0; s < 2; s++) begin
                        if (amp[s] > 32767) begin
                            smp[s] = 16'($urandom);
                        end else begin
                            mag = $urandom_range(0, amp[s]);
                            smp[s] = ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
                        end
                    end
                    last = (f == len - 1) || ($urandom_range(0, 19) == 0);
                    send_item(OP_FRAME, smp[0], smp[1], last, 1'b0, 1'b0, '0);
                    phase_items++;
                end
            end
        end

        wait_drained();
        $display("Checked %0d block levels from %0d input transactions over %0d cycles.",
                 blocks_checked, items_sent, cycle_count);
        $display("Slot choice latched %0d times, %0d blocks closed at full size, %0d threshold writes.",
                 latches, full_blocks, cfg_writes);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
rtl/sdlm_pkg.sv
rtl/sdlm_ctrl.sv
rtl/sdlm_dp.sv
rtl/stereo_slot_detect_level_meter.sv
sim/tb_stereo_slot_detect_level_meter.sv
